// ===== rtl/ssh_pkg.sv =====
// shared types, constants and series coefficients for the stereo sine saturator
package ssh_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int FRAC_W     = SAMPLE_W - 1;
  localparam int LP_W       = SAMPLE_W + 12;
  localparam int GAIN_W     = 19;
  localparam int COEF_W     = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = GAIN_W;
  localparam int ANGLE_W    = 37;

  localparam logic [GAIN_W-1:0] GAIN_MAX = 19'd262144;
  localparam logic [COEF_W-1:0] Q16_ONE  = 17'd65536;

  localparam logic signed [32:0] SAT_MAX = (33'sd1 <<< FRAC_W) - 33'sd1;
  localparam logic signed [32:0] SAT_MIN = -(33'sd1 <<< FRAC_W);

  localparam logic [37:0]        TWO_PI_U  = 38'd6746518852;
  localparam logic [37:0]        PI_U      = 38'd3373259426;
  localparam logic signed [34:0] TWO_PI_S  = 35'sd6746518852;
  localparam logic signed [34:0] PI_S      = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_S = 35'sd1686629713;

  localparam logic [2:0] SERIES_TOP = 3'd5;
  localparam logic [2:0] REDUCE_TOP = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DRIVE_GAIN    = 3'd0,
    REG_HIGHPASS_COEF = 3'd1,
    REG_PRESENCE_MIX  = 3'd2,
    REG_OUTPUT_LEVEL  = 3'd3,
    REG_WET_MIX       = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [COEF_W-1:0] coef;
    logic [COEF_W-1:0] pm;
    logic [COEF_W-1:0] lvl;
    logic [COEF_W-1:0] wet;
  } cfg_t;

  typedef struct packed {
    logic                       phase;
    logic signed [SAMPLE_W-1:0] right;
    logic signed [SAMPLE_W-1:0] left;
  } item_t;

  typedef struct packed {
    logic               start;
    logic [ANGLE_W-1:0] angle;
  } sinc_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] value;
  } sinc_rsp_t;

  function automatic logic signed [33:0] series_coef(input logic [2:0] idx);
    logic signed [33:0] c;
    unique case (idx)
      3'd0:    c = 34'sd1073741824;
      3'd1:    c = -34'sd178956971;
      3'd2:    c = 34'sd8947849;
      3'd3:    c = -34'sd213044;
      3'd4:    c = 34'sd2959;
      3'd5:    c = -34'sd27;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/stereo_sine_saturator_highpass.sv =====
// top level: configuration registers, input queue, channel sequencer and sinc unit
// the channel sequencer works on one stereo beat at a time; the shared sinc unit runs up to four
//   times per beat, with range reduction and divide only for angles of one and above
// the input queue holds two beats, so input is taken while a result waits on the output
// reset: asynchronous active low, clears lowpass states, previous samples and phase
module stereo_sine_saturator_highpass (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // sample_left [23:0], sample_right [47:24]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // result_left [23:0], result_right [47:24]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [18:0] cfg_data_i
);
  import ssh_pkg::*;

  logic [GAIN_W-1:0] gain_q;
  logic [COEF_W-1:0] coef_q, pm_q, lvl_q, wet_q;
  cfg_t      cfg_c;
  item_t     item;
  logic      item_valid, pop;
  sinc_req_t sinc_req;
  sinc_rsp_t sinc_rsp;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= 19'd65536;
      coef_q <= '0;
      pm_q   <= '0;
      lvl_q  <= Q16_ONE;
      wet_q  <= Q16_ONE;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_DRIVE_GAIN:    gain_q <= cfg_data_i;
        REG_HIGHPASS_COEF: coef_q <= cfg_data_i[COEF_W-1:0];
        REG_PRESENCE_MIX:  pm_q   <= cfg_data_i[COEF_W-1:0];
        REG_OUTPUT_LEVEL:  lvl_q  <= cfg_data_i[COEF_W-1:0];
        REG_WET_MIX:       wet_q  <= cfg_data_i[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_c.gain = (gain_q > GAIN_MAX) ? GAIN_MAX : gain_q;
  assign cfg_c.coef = (coef_q > Q16_ONE) ? Q16_ONE : coef_q;
  assign cfg_c.pm   = (pm_q > Q16_ONE) ? Q16_ONE : pm_q;
  assign cfg_c.lvl  = (lvl_q > Q16_ONE) ? Q16_ONE : lvl_q;
  assign cfg_c.wet  = (wet_q > Q16_ONE) ? Q16_ONE : wet_q;

  ssh_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .item_valid_o (item_valid),
    .item_o       (item),
    .pop_i        (pop)
  );

  ssh_sinc u_sinc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sinc_req),
    .rsp_o  (sinc_rsp)
  );

  ssh_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_c),
    .item_valid_i (item_valid),
    .item_i       (item),
    .pop_o        (pop),
    .sinc_req_o   (sinc_req),
    .sinc_rsp_i   (sinc_rsp),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata)
  );

endmodule

// ===== rtl/ssh_front.sv =====
// input stage: takes stereo beats, tags each with its lowpass phase, two-entry queue
module ssh_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [47:0]   in_data_i,
  output logic          item_valid_o,
  output ssh_pkg::item_t item_o,
  input  logic          pop_i
);
  import ssh_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q, phase_q;
  logic [1:0] cnt_q;
  logic       push;

  assign in_ready_o   = (cnt_q != 2'd2);
  assign push         = in_valid_i && in_ready_o;
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      phase_q  <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
        phase_q  <= ~phase_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{phase: phase_q,
                           right: in_data_i[2*SAMPLE_W-1:SAMPLE_W],
                           left:  in_data_i[SAMPLE_W-1:0]};
    end
  end

endmodule

// ===== rtl/ssh_sinc.sv =====
// shared sin(a)/a unit: range reduction, series, restoring divide
module ssh_sinc (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ssh_pkg::sinc_req_t  req_i,
  output ssh_pkg::sinc_rsp_t  rsp_o
);
  import ssh_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE    = 11'h001,
    S_REDUCE  = 11'h002,
    S_FOLD1   = 11'h004,
    S_FOLD2   = 11'h008,
    S_SQUARE  = 11'h010,
    S_SERIES  = 11'h020,
    S_ROUND   = 11'h040,
    S_SINMUL  = 11'h080,
    S_DIVINIT = 11'h100,
    S_DIV     = 11'h200,
    S_QOUT    = 11'h400
  } state_e;

  state_e state_q, state_d;
  logic [4:0] k_q, k_d;
  logic small_q, small_d, done_q, done_d;
  logic [37:0] rem_q, rem_d;
  logic signed [34:0] r_q, r_d;
  logic signed [33:0] w_q, w_d, p_q, p_d;
  logic signed [32:0] sn_q, sn_d;
  logic neg_q, neg_d;
  logic [29:0] quo_q, quo_d, nb_q, nb_d;
  logic [ANGLE_W-1:0] den_q, den_d;
  logic signed [31:0] res_q, res_d;

  logic signed [33:0] ma, mb;
  logic signed [67:0] prod, rnd30;
  logic signed [33:0] rnd30_w;
  logic [37:0] sub, trial;
  logic [32:0] mag;
  logic signed [34:0] p_rnd;

  assign prod    = ma * mb;
  assign rnd30   = (prod + 68'sd536870912) >>> 30;
  assign rnd30_w = rnd30[33:0];
  assign sub     = TWO_PI_U << k_q[2:0];
  assign trial   = {rem_q[36:0], nb_q[29]};
  assign mag     = sn_q[32] ? 33'(-sn_q) : 33'(sn_q);
  assign p_rnd   = (35'(p_q) + 35'sd2) >>> 2;

  assign rsp_o.done  = done_q;
  assign rsp_o.value = res_q;

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_q)
      S_SQUARE: begin
        ma = 34'(r_q);
        mb = 34'(r_q);
      end
      S_SERIES: begin
        ma = p_q;
        mb = w_q;
      end
      S_SINMUL: begin
        ma = p_q;
        mb = 34'(r_q);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    small_d = small_q;
    done_d  = 1'b0;
    rem_d   = rem_q;
    r_d     = r_q;
    w_d     = w_q;
    p_d     = p_q;
    sn_d    = sn_q;
    neg_d   = neg_q;
    quo_d   = quo_q;
    nb_d    = nb_q;
    den_d   = den_q;
    res_d   = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_i.start) begin
          den_d = req_i.angle;
          if (req_i.angle[ANGLE_W-1:30] == '0) begin
            r_d     = 35'(req_i.angle);
            small_d = 1'b1;
            state_d = S_SQUARE;
          end else begin
            rem_d   = 38'(req_i.angle);
            k_d     = 5'(REDUCE_TOP);
            small_d = 1'b0;
            state_d = S_REDUCE;
          end
        end
      end
      S_REDUCE: begin
        if (rem_q >= sub) begin
          rem_d = rem_q - sub;
        end
        k_d = k_q - 5'd1;
        if (k_q == 5'd0) begin
          state_d = S_FOLD1;
        end
      end
      S_FOLD1: begin
        r_d = (rem_q > PI_U) ? 35'(rem_q) - TWO_PI_S : 35'(rem_q);
        state_d = S_FOLD2;
      end
      S_FOLD2: begin
        if (r_q > HALF_PI_S) begin
          r_d = PI_S - r_q;
        end else if (r_q < -HALF_PI_S) begin
          r_d = -PI_S - r_q;
        end
        state_d = S_SQUARE;
      end
      S_SQUARE: begin
        w_d     = rnd30_w;
        p_d     = series_coef(SERIES_TOP);
        k_d     = 5'(SERIES_TOP - 3'd1);
        state_d = S_SERIES;
      end
      S_SERIES: begin
        p_d = series_coef(k_q[2:0]) + rnd30_w;
        k_d = k_q - 5'd1;
        if (k_q == 5'd0) begin
          state_d = small_q ? S_ROUND : S_SINMUL;
        end
      end
      S_ROUND: begin
        res_d   = 32'(p_rnd);
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_SINMUL: begin
        sn_d    = rnd30[32:0];
        state_d = S_DIVINIT;
      end
      S_DIVINIT: begin
        neg_d   = sn_q[32];
        rem_d   = 38'(mag >> 2);
        nb_d    = {mag[1:0], 28'd0};
        quo_d   = '0;
        k_d     = 5'd29;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (trial >= {1'b0, den_q}) begin
          rem_d = trial - {1'b0, den_q};
          quo_d = {quo_q[28:0], 1'b1};
        end else begin
          rem_d = trial;
          quo_d = {quo_q[28:0], 1'b0};
        end
        nb_d = {nb_q[28:0], 1'b0};
        k_d  = k_q - 5'd1;
        if (k_q == 5'd0) begin
          state_d = S_QOUT;
        end
      end
      S_QOUT: begin
        res_d   = neg_q ? -32'(quo_q) : 32'(quo_q);
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q     <= k_d;
    small_q <= small_d;
    rem_q   <= rem_d;
    r_q     <= r_d;
    w_q     <= w_d;
    p_q     <= p_d;
    sn_q    <= sn_d;
    neg_q   <= neg_d;
    quo_q   <= quo_d;
    nb_q    <= nb_d;
    den_q   <= den_d;
    res_q   <= res_d;
  end

endmodule

// ===== rtl/ssh_back.sv =====
// channel sequencer: gain, highpass, shaping, level, blend, mix and output register
module ssh_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ssh_pkg::cfg_t      cfg_i,
  input  logic               item_valid_i,
  input  ssh_pkg::item_t     item_i,
  output logic               pop_o,
  output ssh_pkg::sinc_req_t sinc_req_o,
  input  ssh_pkg::sinc_rsp_t sinc_rsp_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [47:0]        out_data_o
);
  import ssh_pkg::*;

  typedef enum logic [18:0] {
    ST_IDLE   = 19'h00001,
    ST_GAIN   = 19'h00002,
    ST_LPDIFF = 19'h00004,
    ST_LPUPD  = 19'h00008,
    ST_HIGH   = 19'h00010,
    ST_SCALE  = 19'h00020,
    ST_AMAIN  = 19'h00040,
    ST_WMAIN  = 19'h00080,
    ST_YMAIN  = 19'h00100,
    ST_APRES  = 19'h00200,
    ST_WPRES  = 19'h00400,
    ST_YPRES  = 19'h00800,
    ST_LVLY   = 19'h01000,
    ST_LVLP   = 19'h02000,
    ST_DBLEND = 19'h04000,
    ST_BLEND  = 19'h08000,
    ST_DMIX   = 19'h10000,
    ST_MIX    = 19'h20000,
    ST_DONE   = 19'h40000
  } state_e;

  state_e state_q, state_d;
  logic ch_q, ch_d, out_valid_q, out_valid_d;
  logic signed [LP_W-1:0] lpa_l_q, lpa_l_d, lpa_r_q, lpa_r_d;
  logic signed [LP_W-1:0] lpb_l_q, lpb_l_d, lpb_r_q, lpb_r_d;
  logic signed [SAMPLE_W-1:0] prev_l_q, prev_l_d, prev_r_q, prev_r_d;

  logic signed [SAMPLE_W-1:0] x_q, x_d, res_l_q, res_l_d, res_r_q, res_r_d;
  logic signed [SAMPLE_W-1:0] out_l_q, out_l_d, out_r_q, out_r_d;
  logic signed [26:0] g_q, g_d;
  logic signed [37:0] diff_q, diff_d;
  logic signed [LP_W-1:0] lpn_q, lpn_d;
  logic signed [27:0] h_q, h_d;
  logic [27:0] ah_q, ah_d;
  logic [25:0] s_q, s_d;
  logic signed [29:0] y_q, y_d, p_q, p_d;
  logic signed [31:0] d_q, d_d;

  logic signed [37:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [69:0] prod, rnd16, flr16, flr18, rnd28;
  logic signed [31:0] r16;
  logic signed [29:0] r28;
  logic signed [LP_W-1:0] lp_sel, f16;
  logic signed [SAMPLE_W-1:0] prev_sel;
  logic [SAMPLE_W-1:0] prev_abs;
  logic signed [LP_W:0] lpr;
  logic signed [28:0] h2;
  logic signed [32:0] o_w;
  logic signed [SAMPLE_W-1:0] sat;

  assign prod  = mul_a * mul_b;
  assign rnd16 = (prod + 70'sd32768) >>> 16;
  assign flr16 = prod >>> 16;
  assign flr18 = prod >>> 18;
  assign rnd28 = (prod + 70'sd134217728) >>> 28;
  assign r16   = rnd16[31:0];
  assign r28   = rnd28[29:0];
  assign f16   = flr16[LP_W-1:0];

  assign prev_sel = ch_q ? prev_r_q : prev_l_q;
  assign prev_abs = prev_sel[SAMPLE_W-1] ? SAMPLE_W'(-(SAMPLE_W+1)'(prev_sel))
                                         : SAMPLE_W'(prev_sel);
  assign lpr = ((LP_W+1)'(lpn_q) + (LP_W+1)'(512)) >>> 10;
  assign h2  = 29'(h_q) <<< 1;
  assign o_w = 33'(x_q) + 33'(r16);
  assign sat = (o_w > SAT_MAX) ? SAMPLE_W'(SAT_MAX) :
               (o_w < SAT_MIN) ? SAMPLE_W'(SAT_MIN) : o_w[SAMPLE_W-1:0];

  always_comb begin
    unique case ({ch_q, item_i.phase})
      2'b00:   lp_sel = lpb_l_q;
      2'b01:   lp_sel = lpa_l_q;
      2'b10:   lp_sel = lpb_r_q;
      default: lp_sel = lpa_r_q;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_GAIN: begin
        mul_a = 38'(x_q);
        mul_b = 32'(cfg_i.gain);
      end
      ST_LPUPD: begin
        mul_a = diff_q;
        mul_b = 32'(cfg_i.coef);
      end
      ST_SCALE: begin
        mul_a = 38'(prev_abs);
        mul_b = 32'(cfg_i.gain);
      end
      ST_AMAIN: begin
        mul_a = 38'(ah_q);
        mul_b = 32'(ah_q);
      end
      ST_APRES: begin
        mul_a = 38'(ah_q);
        mul_b = 32'({s_q, 1'b0});
      end
      ST_YMAIN, ST_YPRES: begin
        mul_a = 38'(h_q);
        mul_b = sinc_rsp_i.value;
      end
      ST_LVLY: begin
        mul_a = 38'(y_q);
        mul_b = 32'(cfg_i.lvl);
      end
      ST_LVLP: begin
        mul_a = 38'(p_q);
        mul_b = 32'(cfg_i.lvl);
      end
      ST_BLEND: begin
        mul_a = 38'(d_q);
        mul_b = 32'(cfg_i.pm);
      end
      ST_MIX: begin
        mul_a = 38'(d_q);
        mul_b = 32'(cfg_i.wet);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    lpa_l_d = lpa_l_q;
    lpa_r_d = lpa_r_q;
    lpb_l_d = lpb_l_q;
    lpb_r_d = lpb_r_q;
    prev_l_d = prev_l_q;
    prev_r_d = prev_r_q;
    out_valid_d = out_valid_q && !out_ready_i;
    x_d = x_q;
    g_d = g_q;
    diff_d = diff_q;
    lpn_d = lpn_q;
    h_d = h_q;
    ah_d = ah_q;
    s_d = s_q;
    y_d = y_q;
    p_d = p_q;
    d_d = d_q;
    res_l_d = res_l_q;
    res_r_d = res_r_q;
    out_l_d = out_l_q;
    out_r_d = out_r_q;
    pop_o = 1'b0;
    sinc_req_o.start = 1'b0;
    sinc_req_o.angle = flr18[ANGLE_W-1:0];
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          x_d     = item_i.left;
          ch_d    = 1'b0;
          state_d = ST_GAIN;
        end
      end
      ST_GAIN: begin
        g_d     = rnd16[26:0];
        state_d = ST_LPDIFF;
      end
      ST_LPDIFF: begin
        diff_d  = (38'(g_q) <<< 10) - 38'(lp_sel);
        state_d = ST_LPUPD;
      end
      ST_LPUPD: begin
        lpn_d = lp_sel + f16;
        unique case ({ch_q, item_i.phase})
          2'b00:   lpb_l_d = lp_sel + f16;
          2'b01:   lpa_l_d = lp_sel + f16;
          2'b10:   lpb_r_d = lp_sel + f16;
          default: lpa_r_d = lp_sel + f16;
        endcase
        state_d = ST_HIGH;
      end
      ST_HIGH: begin
        h_d     = 28'(g_q) - 28'(lpr);
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        ah_d    = h_q[27] ? 28'(-h2) : 28'(h2);
        s_d     = flr16[25:0];
        state_d = ST_AMAIN;
      end
      ST_AMAIN: begin
        sinc_req_o.start = 1'b1;
        state_d = ST_WMAIN;
      end
      ST_WMAIN: begin
        if (sinc_rsp_i.done) begin
          state_d = ST_YMAIN;
        end
      end
      ST_YMAIN: begin
        y_d     = r28;
        state_d = ST_APRES;
      end
      ST_APRES: begin
        if (s_q == '0) begin
          p_d     = '0;
          state_d = ST_LVLY;
        end else begin
          sinc_req_o.start = 1'b1;
          state_d = ST_WPRES;
        end
      end
      ST_WPRES: begin
        if (sinc_rsp_i.done) begin
          state_d = ST_YPRES;
        end
      end
      ST_YPRES: begin
        p_d     = r28;
        state_d = ST_LVLY;
      end
      ST_LVLY: begin
        y_d     = r16[29:0];
        state_d = ST_LVLP;
      end
      ST_LVLP: begin
        p_d     = r16[29:0];
        state_d = ST_DBLEND;
      end
      ST_DBLEND: begin
        d_d     = 32'(p_q) - 32'(y_q);
        state_d = ST_BLEND;
      end
      ST_BLEND: begin
        y_d     = y_q + r16[29:0];
        state_d = ST_DMIX;
      end
      ST_DMIX: begin
        d_d     = 32'(y_q) - 32'(x_q);
        state_d = ST_MIX;
      end
      ST_MIX: begin
        if (ch_q) begin
          prev_r_d = x_q;
          res_r_d  = sat;
          state_d  = ST_DONE;
        end else begin
          prev_l_d = x_q;
          res_l_d  = sat;
          ch_d     = 1'b1;
          x_d      = item_i.right;
          state_d  = ST_GAIN;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_l_d     = res_l_q;
          out_r_d     = res_r_q;
          out_valid_d = 1'b1;
          pop_o       = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= 1'b0;
      out_valid_q <= 1'b0;
      lpa_l_q     <= '0;
      lpa_r_q     <= '0;
      lpb_l_q     <= '0;
      lpb_r_q     <= '0;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
      lpa_l_q     <= lpa_l_d;
      lpa_r_q     <= lpa_r_d;
      lpb_l_q     <= lpb_l_d;
      lpb_r_q     <= lpb_r_d;
      prev_l_q    <= prev_l_d;
      prev_r_q    <= prev_r_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    g_q     <= g_d;
    diff_q  <= diff_d;
    lpn_q   <= lpn_d;
    h_q     <= h_d;
    ah_q    <= ah_d;
    s_q     <= s_d;
    y_q     <= y_d;
    p_q     <= p_d;
    d_q     <= d_d;
    res_l_q <= res_l_d;
    res_r_q <= res_r_d;
    out_l_q <= out_l_d;
    out_r_q <= out_r_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {out_r_q, out_l_q};

endmodule

// ===== rtl/ssh_checker.sv =====
// port-level checks for the stereo sine saturator, bound to the top level
module ssh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);
  logic [2:0] pend_q;
  logic       in_beat, out_beat;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {2'b0, in_beat} - {2'b0, out_beat};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != 3'd0)
    else $error("output beat without a pending input beat");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd3)
    else $error("more beats in flight than queue and output register hold");

  a_full_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> pend_q >= 3'd2)
    else $error("input stalled while the queue has room");

endmodule

bind stereo_sine_saturator_highpass ssh_checker u_ssh_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== verif/stereo_sine_saturator_highpass_tb.sv =====
// testbench for the stereo sine saturator: directed table, random phases, self-checking predictor
`timescale 1ns / 1ps

module stereo_sine_saturator_highpass_tb;
  import ssh_pkg::*;

  localparam int          CYCLE_LIMIT = 1500000;
  localparam int          MAX_REPORTS = 10;
  localparam logic [2:0]  REG_UNUSED  = 3'd7;
  localparam longint      ANGLE_ONE   = 64'sd1 << 30;
  localparam longint      PI_A        = 64'sd3373259426;
  localparam longint      TWO_PI_A    = 64'sd6746518852;
  localparam longint      HALF_PI_A   = 64'sd1686629713;
  localparam logic [23:0] S_MAX       = 24'h7fffff;
  localparam logic [23:0] S_MIN       = 24'h800000;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [2:0]  idx;
    logic [18:0] val;
    logic [23:0] l, r;
    bit          typed;
    logic [23:0] el, er;
  } row_t;

  typedef struct {
    logic [23:0] left, right;
  } pair_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [18:0] cfg_data_i = '0;

  longint gain_r, coef_r, pm_r, lvl_r, wet_r;
  longint lp_a_l, lp_a_r, lp_b_l, lp_b_r, prev_l, prev_r;
  bit     toggle;

  pair_t  pending_pairs[$];
  pair_t  typed_pairs[$];
  bit     typed_flags[$];
  int     mismatches = 0;
  int     beats_in = 0, beats_out = 0, cfg_writes = 0;
  int     cycles = 0;
  bit     idle_on = 1'b1;
  bit     hold_req = 1'b0;

  stereo_sine_saturator_highpass u_top (.*);

  always #10 clk_i = ~clk_i;

  function automatic longint rsr(input longint v, input int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint taylor(input longint w);
    longint k[6];
    longint acc;
    k = '{64'sd1073741824, -64'sd178956971, 64'sd8947849, -64'sd213044, 64'sd2959, -64'sd27};
    acc = k[5];
    for (int i = 4; i >= 0; i--) acc = k[i] + rsr(acc * w, 30);
    return acc;
  endfunction

  function automatic longint sinc_of_angle(input longint a);
    longint r, w, sn;
    if (a < ANGLE_ONE) return rsr(taylor(rsr(a * a, 30)), 2);
    r = a % TWO_PI_A;
    if (r > PI_A) r -= TWO_PI_A;
    if (r > HALF_PI_A) r = PI_A - r;
    else if (r < -HALF_PI_A) r = -PI_A - r;
    w  = rsr(r * r, 30);
    sn = rsr(taylor(w) * r, 30);
    return (sn <<< 28) / a;
  endfunction

  function automatic longint clip(input longint v, input longint top);
    return v > top ? top : v;
  endfunction

  function automatic logic [23:0] shape_sample(input logic [23:0] raw, inout longint lp,
                                               inout longint prev);
    longint x, g, h, ah, y, p, s, m, o, gain, coef, pm, lvl, wet;
    gain = clip(gain_r, 262144);
    coef = clip(coef_r, 65536);
    pm   = clip(pm_r, 65536);
    lvl  = clip(lvl_r, 65536);
    wet  = clip(wet_r, 65536);
    x  = longint'($signed(raw));
    g  = rsr(x * gain, 16);
    lp = lp + ((((g <<< 10) - lp) * coef) >>> 16);
    h  = g - rsr(lp, 10);
    ah = h < 0 ? -2 * h : 2 * h;
    y  = rsr(h * sinc_of_angle((ah * ah) >>> 18), 28);
    s  = ((prev < 0 ? -prev : prev) * gain) >>> 16;
    p  = (s == 0) ? 0 : rsr(h * sinc_of_angle((ah * (2 * s)) >>> 18), 28);
    y  = rsr(y * lvl, 16);
    p  = rsr(p * lvl, 16);
    m  = y + rsr((p - y) * pm, 16);
    o  = x + rsr((m - x) * wet, 16);
    if (o > 8388607) o = 8388607;
    if (o < -8388608) o = -8388608;
    prev = x;
    return o[23:0];
  endfunction

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // predictor update and output comparison
  always @(posedge clk_i) begin
    pair_t e, got, tp;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_writes++;
        case (cfg_index_i)
          REG_DRIVE_GAIN:    gain_r = cfg_data_i;
          REG_HIGHPASS_COEF: coef_r = cfg_data_i[16:0];
          REG_PRESENCE_MIX:  pm_r   = cfg_data_i[16:0];
          REG_OUTPUT_LEVEL:  lvl_r  = cfg_data_i[16:0];
          REG_WET_MIX:       wet_r  = cfg_data_i[16:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        beats_in++;
        if (toggle) begin
          e.left  = shape_sample(s_axis_tdata[23:0], lp_a_l, prev_l);
          e.right = shape_sample(s_axis_tdata[47:24], lp_a_r, prev_r);
        end else begin
          e.left  = shape_sample(s_axis_tdata[23:0], lp_b_l, prev_l);
          e.right = shape_sample(s_axis_tdata[47:24], lp_b_r, prev_r);
        end
        toggle = ~toggle;
        tp = typed_pairs.pop_front();
        if (typed_flags.pop_front()) e = tp;
        pending_pairs.push_back(e);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        beats_out++;
        got.left  = m_axis_tdata[23:0];
        got.right = m_axis_tdata[47:24];
        if (pending_pairs.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected beat %h %h", got.left, got.right);
        end else begin
          e = pending_pairs.pop_front();
          if (got.left !== e.left || got.right !== e.right) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("beat %0d: expected %h %h, got %h %h", beats_out, e.left, e.right,
                       got.left, got.right);
          end
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        for (int n = 0; n < 600; n++) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  task automatic wait_idle();
    while (pending_pairs.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [18:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic put_beat(input logic [23:0] l, input logic [23:0] r, input bit typed,
                          input pair_t tp);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    typed_flags.push_back(typed);
    typed_pairs.push_back(tp);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r, l};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 1) ? S_MAX : S_MIN;
      1:       return 24'(int'($urandom_range(0, 4095)) - 2048);
      2:       return 24'(int'($urandom_range(0, 1048575)) - 524288);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [18:0] rand_reg(input logic [2:0] idx);
    logic [18:0] top;
    top = (idx == REG_DRIVE_GAIN) ? 19'd262144 : 19'd65536;
    case ($urandom_range(0, 7))
      0:       return 19'd0;
      1:       return top;
      2:       return 19'($urandom);
      default: return 19'($urandom_range(0, top));
    endcase
  endfunction

  row_t rows[] = '{
    '{ROW_BEAT, 3'd0, 19'd0, 24'h000000, 24'h000000, 1, 24'h000000, 24'h000000},
    '{ROW_BEAT, 3'd0, 19'd0, S_MAX, S_MIN, 0, 24'h0, 24'h0},
    '{ROW_BEAT, 3'd0, 19'd0, S_MIN, S_MAX, 0, 24'h0, 24'h0},
    '{ROW_BEAT, 3'd0, 19'd0, 24'hffffff, 24'h000001, 0, 24'h0, 24'h0},
    '{ROW_BEAT, 3'd0, 19'd0, 24'h000000, 24'h000000, 1, 24'h000000, 24'h000000},
    '{ROW_CFG, REG_WET_MIX, 19'd0, 24'h0, 24'h0, 0, 24'h0, 24'h0},
    '{ROW_BEAT, 3'd0, 19'd0, S_MAX, S_MIN, 1, S_MAX, S_MIN},
    '{ROW_BEAT, 3'd0, 19'd0, 24'h123456, 24'hedcba9, 1, 24'h123456, 24'hedcba9},
    '{ROW_CFG, REG_DRIVE_GAIN, 19'd262144, 24'h0, 24'h0, 0, 24'h0, 24'h0},
    '{ROW_CFG, REG_HIGHPASS_COEF, 19'd65536, 24'h0, 24'h0, 0, 24'h0, 24'h0},
    '{ROW_CFG, REG_PRESENCE_MIX, 19'd65536, 24'h0, 24'h0, 0, 24'h0, 24'h0},
    '{ROW_CFG, REG_OUTPUT_LEVEL, 19'd0, 24'h0, 24'h0, 0, 24'h0, 24'h0},
    '{ROW_CFG, REG_WET_MIX, 19'd65536, 24'h0, 24'h0, 0, 24'h0, 24'h0},
    '{ROW_BEAT, 3'd0, 19'd0, S_MAX, S_MIN, 0, 24'h0, 24'h0},
    '{ROW_BEAT, 3'd0, 19'd0, 24'h400000, 24'hc00000, 0, 24'h0, 24'h0},
    '{ROW_CFG, REG_OUTPUT_LEVEL, 19'd65536, 24'h0, 24'h0, 0, 24'h0, 24'h0},
    '{ROW_BEAT, 3'd0, 19'd0, S_MIN, S_MAX, 0, 24'h0, 24'h0},
    '{ROW_BEAT, 3'd0, 19'd0, 24'h000000, 24'h000000, 0, 24'h0, 24'h0},
    '{ROW_CFG, REG_DRIVE_GAIN, 19'h7ffff, 24'h0, 24'h0, 0, 24'h0, 24'h0},
    '{ROW_CFG, REG_HIGHPASS_COEF, 19'h1ffff, 24'h0, 24'h0, 0, 24'h0, 24'h0},
    '{ROW_CFG, REG_UNUSED, 19'h55555, 24'h0, 24'h0, 0, 24'h0, 24'h0},
    '{ROW_BEAT, 3'd0, 19'd0, 24'h2aaaaa, 24'hd55555, 0, 24'h0, 24'h0},
    '{ROW_BEAT, 3'd0, 19'd0, S_MAX, S_MAX, 0, 24'h0, 24'h0}
  };

  initial begin
    pair_t none;
    logic [2:0] idx;
    int n_items;
    none = '{24'h0, 24'h0};
    gain_r = 65536; coef_r = 0; pm_r = 0; lvl_r = 65536; wet_r = 65536;
    lp_a_l = 0; lp_a_r = 0; lp_b_l = 0; lp_b_r = 0; prev_l = 0; prev_r = 0;
    toggle = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        s_axis_tvalid <= 1'b0;
        wait_idle();
        write_reg(rows[i].idx, rows[i].val);
      end else begin
        put_beat(rows[i].l, rows[i].r, rows[i].typed, '{rows[i].el, rows[i].er});
      end
    end

    for (int ph = 0; ph < 9; ph++) begin
      s_axis_tvalid <= 1'b0;
      wait_idle();
      idle_on = (ph < 7);
      for (int k = 0; k < 5; k++) begin
        idx = 3'(k);
        if (ph == 0 || $urandom_range(0, 2) != 0) write_reg(idx, rand_reg(idx));
      end
      if (ph == 3) write_reg(REG_WET_MIX, 19'd65536);
      n_items = $urandom_range(80, 110);
      for (int i = 0; i < n_items; i++) begin
        if (ph == 2 && i == 10) hold_req = 1'b1;
        if (ph == 4 && i == 50) begin
          s_axis_tvalid <= 1'b0;
          wait_idle();
        end
        put_beat(rand_sample(), rand_sample(), 1'b0, none);
      end
    end
    s_axis_tvalid <= 1'b0;

    wait_idle();
    repeat (300) @(posedge clk_i);
    if (pending_pairs.size() != 0) mismatches += pending_pairs.size();
    $display("covered %0d stereo beats in, %0d out, %0d register writes", beats_in,
             beats_out, cfg_writes);
    $display("directed extremes, over-range registers, presence and highpass settings");
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ===== stereo_sine_saturator_highpass.f =====
rtl/ssh_pkg.sv
rtl/ssh_front.sv
rtl/ssh_sinc.sv
rtl/ssh_back.sv
rtl/stereo_sine_saturator_highpass.sv
rtl/ssh_checker.sv
verif/stereo_sine_saturator_highpass_tb.sv
